FILE: src/sem_pkg.sv
`default_nettype none

package sem_pkg;

    localparam int PIXEL_W           = 8;
    localparam int MAG_W             = 11;
    localparam int WIDTH_REG_W       = 11;
    localparam int HEIGHT_REG_W      = 13;
    localparam int CFG_DATA_W        = 13;
    localparam int CFG_INDEX_W       = 2;
    localparam int MAX_WIDTH_DEFAULT = 1024;
    localparam int MAX_HEIGHT        = 4096;
    localparam int WIDTH_RESET       = 512;
    localparam int HEIGHT_RESET      = 512;

    // Signed gradient and root accumulator widths (|g| <= 1020, sum < 2^21)
    localparam int GRAD_W     = 11;
    localparam int ACC_W      = 2 * GRAD_W;
    localparam int SQRT_STEPS = 11;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } cfg_reg_t;

    typedef logic [PIXEL_W-1:0] pixel_t;

    typedef struct packed {
        pixel_t top;
        pixel_t mid;
        pixel_t bot;
    } column_t;

    typedef struct packed {
        pixel_t upper;
        pixel_t middle;
    } line_word_t;

    // Per-pixel request from the counter stage to the line buffer
    typedef struct packed {
        pixel_t v;
        logic   top_ok;
        logic   mid_ok;
        logic   left_ok;
        logic   edge_res;
        logic   inner_res;
        logic   last;
    } pix_req_t;

    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic                     last;
    } grad_t;

    function automatic logic signed [GRAD_W-1:0] ext_pixel(input pixel_t p);
        return $signed(GRAD_W'(p));
    endfunction

endpackage

`default_nettype wire

FILE: src/sem_pixel_if.sv
`default_nettype none

interface sem_pixel_if;
    import sem_pkg::*;

    logic   valid;
    logic   ready;
    pixel_t pixel;

    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

`default_nettype wire

FILE: src/sem_result_if.sv
`default_nettype none

interface sem_result_if;
    import sem_pkg::*;

    logic             valid;
    logic             ready;
    logic [MAG_W-1:0] magnitude;
    logic             last_of_frame;

    modport source (output valid, output magnitude, output last_of_frame, input ready);
    modport sink (input valid, input magnitude, input last_of_frame, output ready);
endinterface

`default_nettype wire

FILE: src/sem_line_buf.sv
`default_nettype none

module sem_line_buf #(
    parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEFAULT,
    parameter int COL_W     = $clog2(MAX_WIDTH)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    input  wire sem_pkg::pix_req_t  req,
    input  wire logic [COL_W-1:0]   req_col,
    output logic                    req_ready,
    output logic                    grad_valid,
    output sem_pkg::grad_t          grad,
    input  wire logic               grad_ready
);
    import sem_pkg::*;

    line_word_t mem [MAX_WIDTH];
    line_word_t q_reg;

    logic       p2_valid_reg;
    pix_req_t   p2_reg;
    logic [COL_W-1:0] p2_col_reg;
    logic       fwd_reg;
    line_word_t fwd_data_reg;
    column_t    win_l_reg;
    column_t    win_c_reg;

    logic       has_res;
    logic       p2_adv;
    line_word_t word;
    line_word_t wr_word;
    column_t    new_col;

    logic signed [GRAD_W-1:0] l_t, l_m, l_b, c_t, c_b, r_t, r_m, r_b;

    assign has_res    = p2_reg.edge_res || p2_reg.inner_res;
    assign p2_adv     = p2_valid_reg && (!has_res || grad_ready);
    assign req_ready  = !p2_valid_reg || p2_adv;
    assign grad_valid = p2_valid_reg && has_res;

    // Take the entry just written back when the read raced the write
    assign word        = fwd_reg ? fwd_data_reg : q_reg;
    assign new_col.top = p2_reg.top_ok ? word.upper : '0;
    assign new_col.mid = p2_reg.mid_ok ? word.middle : '0;
    assign new_col.bot = p2_reg.v;

    assign wr_word.upper  = word.middle;
    assign wr_word.middle = p2_reg.v;

    always_ff @(posedge clk)
    begin
        if (p2_adv)
        begin
            mem[p2_col_reg] <= wr_word;
        end
        if (req_valid)
        begin
            q_reg <= mem[req_col];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid)
        begin
            p2_reg       <= req;
            p2_col_reg   <= req_col;
            fwd_data_reg <= wr_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
            win_l_reg    <= '0;
            win_c_reg    <= '0;
        end
        else
        begin
            if (req_valid)
            begin
                p2_valid_reg <= 1'b1;
                fwd_reg      <= p2_adv && (p2_col_reg == req_col);
            end
            else if (p2_adv)
            begin
                p2_valid_reg <= 1'b0;
            end
            if (p2_adv)
            begin
                win_l_reg <= win_c_reg;
                win_c_reg <= new_col;
            end
        end
    end

    // Left column may fall outside the frame; right column is absent at a row end
    always_comb
    begin
        l_t = p2_reg.left_ok ? ext_pixel(win_l_reg.top) : '0;
        l_m = p2_reg.left_ok ? ext_pixel(win_l_reg.mid) : '0;
        l_b = p2_reg.left_ok ? ext_pixel(win_l_reg.bot) : '0;
        c_t = ext_pixel(win_c_reg.top);
        c_b = ext_pixel(win_c_reg.bot);
        r_t = p2_reg.inner_res ? ext_pixel(new_col.top) : '0;
        r_m = p2_reg.inner_res ? ext_pixel(new_col.mid) : '0;
        r_b = p2_reg.inner_res ? ext_pixel(new_col.bot) : '0;
        grad.gx   = (r_t - l_t) + ((r_m - l_m) <<< 1) + (r_b - l_b);
        grad.gy   = (l_b + (c_b <<< 1) + r_b) - (l_t + (c_t <<< 1) + r_t);
        grad.last = p2_reg.last;
    end

endmodule

`default_nettype wire

FILE: src/sem_isqrt.sv
`default_nettype none

module sem_isqrt (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire sem_pkg::grad_t           in_grad,
    output logic                          in_ready,
    output logic                          out_valid,
    output logic [sem_pkg::MAG_W-1:0]     out_magnitude,
    output logic                          out_last,
    input  wire logic                     out_ready
);
    import sem_pkg::*;

    logic  adv;
    logic  s0_valid_reg;
    grad_t s0_reg;
    logic signed [ACC_W-1:0] sq_x;
    logic signed [ACC_W-1:0] sq_y;

    logic             valid_reg [SQRT_STEPS+1];
    logic [ACC_W-1:0] rem_reg   [SQRT_STEPS+1];
    logic [ACC_W-1:0] res_reg   [SQRT_STEPS+1];
    logic             last_reg  [SQRT_STEPS+1];

    logic [ACC_W-1:0] trial    [SQRT_STEPS];
    logic [ACC_W-1:0] rem_next [SQRT_STEPS];
    logic [ACC_W-1:0] res_next [SQRT_STEPS];

    // Whole pipeline moves together; stall only when the output is held
    assign adv      = !valid_reg[SQRT_STEPS] || out_ready;
    assign in_ready = adv;

    assign sq_x = s0_reg.gx * s0_reg.gx;
    assign sq_y = s0_reg.gy * s0_reg.gy;

    always_comb
    begin
        for (int k = 0; k < SQRT_STEPS; k++)
        begin
            trial[k] = res_reg[k] + (ACC_W'(1) << (2 * (SQRT_STEPS - 1 - k)));
            if (rem_reg[k] >= trial[k])
            begin
                rem_next[k] = rem_reg[k] - trial[k];
                res_next[k] = (res_reg[k] >> 1) + (ACC_W'(1) << (2 * (SQRT_STEPS - 1 - k)));
            end
            else
            begin
                rem_next[k] = rem_reg[k];
                res_next[k] = res_reg[k] >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_reg      <= in_grad;
            rem_reg[0]  <= $unsigned(sq_x) + $unsigned(sq_y);
            res_reg[0]  <= '0;
            last_reg[0] <= s0_reg.last;
            for (int k = 0; k < SQRT_STEPS; k++)
            begin
                rem_reg[k+1]  <= rem_next[k];
                res_reg[k+1]  <= res_next[k];
                last_reg[k+1] <= last_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            for (int k = 0; k <= SQRT_STEPS; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            s0_valid_reg <= in_valid;
            valid_reg[0] <= s0_valid_reg;
            for (int k = 0; k < SQRT_STEPS; k++)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end
    end

    assign out_valid     = valid_reg[SQRT_STEPS];
    assign out_magnitude = res_reg[SQRT_STEPS][MAG_W-1:0];
    assign out_last      = last_reg[SQRT_STEPS];

endmodule

`default_nettype wire

FILE: src/sobel_edge_magnitude.sv
// Sobel edge magnitude over a raster stream of 8-bit gray pixels.
//
// Channels: "pixels" carries one gray pixel per request in raster order;
// "results" carries floor(sqrt(gx^2 + gy^2)) and a last_of_frame flag on the
// frame's final position. Both use valid/ready; a request moves when both are
// high. After each frame, send frame_width+1 padding requests (any value) so
// the bottom row drains; the first frame_width+1 requests of a frame give no
// result, every later request gives exactly one.
// Configuration: cfg_write with cfg_index 0 (frame_width) or 1 (frame_height)
// loads the register and restarts the frame. Write only while idle.
// Throughput: one pixel per clock unless a held result stalls it, set by the single
// line-store memory that takes one read and one write-back per pixel. A result
// passes the memory read, the gradient and square stages and eleven root steps
// before it shows on results.
// Reset: counters restart at the first pixel of a frame, width and height go
// to 512. Line stores are not cleared; rows not yet written are masked.
// Stall: a held result freezes the root pipeline; pixels that give no result
// still enter, and one more waits in the line-buffer stage before pixels stop.
`default_nettype none

module sobel_edge_magnitude #(
    parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    sem_pixel_if.sink                              pixels,
    sem_result_if.source                           results,
    input  wire logic                              cfg_write,
    input  wire logic [sem_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [sem_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import sem_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);

    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic [COL_W-1:0]        col_reg,  col_next;
    logic [HEIGHT_REG_W-1:0] row_reg,  row_next;

    logic [WW-1:0]           eff_w;
    logic [HEIGHT_REG_W-1:0] eff_h;
    logic                    cfg_hit;
    logic                    accept;
    logic                    lb_ready;
    pix_req_t                req;

    logic  grad_valid;
    grad_t grad;
    logic  root_ready;

    // Clamp the frame geometry: width to what the line stores can hold, height to MAX_HEIGHT, zero to one
    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_w = WW'(1);
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            eff_w = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WW'(width_reg);
        end

        if (height_reg == '0)
        begin
            eff_h = HEIGHT_REG_W'(1);
        end
        else if (height_reg > HEIGHT_REG_W'(MAX_HEIGHT))
        begin
            eff_h = HEIGHT_REG_W'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = height_reg;
        end
    end

    assign accept       = pixels.valid && lb_ready;
    assign pixels.ready = lb_ready;

    // Classify the pixel position: result on the row's wrap or inside the row
    always_comb
    begin
        req.v         = (row_reg < eff_h) ? pixels.pixel : '0;
        req.top_ok    = row_reg >= HEIGHT_REG_W'(2);
        req.mid_ok    = row_reg != '0;
        req.edge_res  = (col_reg == '0) && (row_reg >= HEIGHT_REG_W'(2));
        req.inner_res = (col_reg != '0) && (row_reg != '0);
        req.last      = req.edge_res && (row_reg == eff_h + HEIGHT_REG_W'(1));
        req.left_ok   = req.edge_res ? (eff_w >= WW'(2)) : (col_reg >= COL_W'(2));
    end

    always_comb
    begin
        case (cfg_index)
            REG_FRAME_WIDTH:  cfg_hit = cfg_write;
            REG_FRAME_HEIGHT: cfg_hit = cfg_write;
            default:          cfg_hit = 1'b0;
        endcase
    end

    // Advance the raster position; wrap the frame after its last result or on a register write
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_hit)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (req.last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (WW'(col_reg) + WW'(1) >= eff_w)
            begin
                col_next = '0;
                row_next = row_reg + HEIGHT_REG_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_REG_W'(WIDTH_RESET);
            height_reg <= HEIGHT_REG_W'(HEIGHT_RESET);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  width_reg  <= cfg_data[WIDTH_REG_W-1:0];
                    REG_FRAME_HEIGHT: height_reg <= cfg_data[HEIGHT_REG_W-1:0];
                    default:          ;
                endcase
            end
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    sem_line_buf #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_line_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (accept),
        .req        (req),
        .req_col    (col_reg),
        .req_ready  (lb_ready),
        .grad_valid (grad_valid),
        .grad       (grad),
        .grad_ready (root_ready)
    );

    sem_isqrt u_isqrt (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (grad_valid),
        .in_grad       (grad),
        .in_ready      (root_ready),
        .out_valid     (results.valid),
        .out_magnitude (results.magnitude),
        .out_last      (results.last_of_frame),
        .out_ready     (results.ready)
    );

    // Column counter never reaches the clamped width
    assert property (@(posedge clk) disable iff (!rst_n)
        WW'(col_reg) < eff_w)
        else $error("column counter beyond frame width");

    // Row counter never passes the padding row
    assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= eff_h + HEIGHT_REG_W'(1))
        else $error("row counter beyond padding row");

    // A register write restarts the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT)
        |=> col_reg == '0 && row_reg == '0)
        else $error("frame not restarted by register write");

endmodule

`default_nettype wire
